// File: sv/lps_pkg.sv
`default_nettype none

package lps_pkg;

    // Width of every coordinate field on the ports.
    localparam int unsigned FIELD_BITS = 16;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_STOP  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] target_y;
        logic [FIELD_BITS-1:0] target_x;
        logic [FIELD_BITS-1:0] start_y;
        logic [FIELD_BITS-1:0] start_x;
        logic [1:0]            mode;
    } item_t;

    typedef struct packed {
        logic                  arrived;
        logic                  moved;
        logic [FIELD_BITS-1:0] pos_y;
        logic [FIELD_BITS-1:0] pos_x;
    } result_t;

endpackage

`default_nettype wire

// File: sv/lps_in_stage.sv
`default_nettype none

module lps_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lps_pkg::item_t in_item,
    output logic               item_valid,
    input  wire logic          item_take,
    output lps_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    lps_pkg::item_t item_reg;

    // The held request leaves in the same cycle a new one may enter.
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: sv/lps_walker.sv
`default_nettype none

module lps_walker #(
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step_en,
    input  wire lps_pkg::item_t item,
    output lps_pkg::result_t    result
);

    localparam int unsigned ERR_BITS = COORD_BITS + 2;

    logic [COORD_BITS-1:0] cur_x_reg, cur_y_reg, goal_x_reg, goal_y_reg;
    logic [COORD_BITS-1:0] delta_x_reg, delta_y_reg;
    logic                  x_down_reg, y_down_reg, x_major_reg, active_reg;
    logic [ERR_BITS-1:0]   err_reg;

    logic [COORD_BITS-1:0] cur_x_next, cur_y_next, goal_x_next, goal_y_next;
    logic [COORD_BITS-1:0] delta_x_next, delta_y_next;
    logic                  x_down_next, y_down_next, x_major_next, active_next;
    logic [ERR_BITS-1:0]   err_next;

    logic [COORD_BITS-1:0] sx, sy, tx, ty, dx, dy;
    logic [COORD_BITS-1:0] maj_d, min_d;
    logic [ERR_BITS-1:0]   err_sum, maj_twice;
    logic                  minor_step;
    logic [COORD_BITS-1:0] x_stepped, y_stepped;
    logic                  moved;

    always_comb begin
        sx = COORD_BITS'(item.start_x);
        sy = COORD_BITS'(item.start_y);
        tx = COORD_BITS'(item.target_x);
        ty = COORD_BITS'(item.target_y);
        dx = (sx >= tx) ? (sx - tx) : (tx - sx);
        dy = (sy >= ty) ? (sy - ty) : (ty - sy);

        // Error update for a tick: add twice the minor delta and take the
        // minor step when the sum passes twice the major delta.
        maj_d      = x_major_reg ? delta_x_reg : delta_y_reg;
        min_d      = x_major_reg ? delta_y_reg : delta_x_reg;
        err_sum    = err_reg + {1'b0, min_d, 1'b0};
        maj_twice  = {1'b0, maj_d, 1'b0};
        minor_step = err_sum > maj_twice;
        x_stepped  = x_down_reg ? (cur_x_reg - COORD_BITS'(1)) : (cur_x_reg + COORD_BITS'(1));
        y_stepped  = y_down_reg ? (cur_y_reg - COORD_BITS'(1)) : (cur_y_reg + COORD_BITS'(1));
    end

    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        goal_x_next  = goal_x_reg;
        goal_y_next  = goal_y_reg;
        delta_x_next = delta_x_reg;
        delta_y_next = delta_y_reg;
        x_down_next  = x_down_reg;
        y_down_next  = y_down_reg;
        x_major_next = x_major_reg;
        err_next     = err_reg;
        active_next  = active_reg;
        moved        = 1'b0;

        unique case (item.mode)
            lps_pkg::MODE_START: begin
                cur_x_next   = sx;
                cur_y_next   = sy;
                goal_x_next  = tx;
                goal_y_next  = ty;
                delta_x_next = dx;
                delta_y_next = dy;
                x_down_next  = !(sx < tx);
                y_down_next  = !(sy < ty);
                x_major_next = dx >= dy;
                err_next     = ERR_BITS'((dx >= dy) ? dx : dy);
                active_next  = !((sx == tx) && (sy == ty));
            end
            lps_pkg::MODE_TICK: begin
                if (active_reg && !((cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg))) begin
                    moved    = 1'b1;
                    err_next = minor_step ? (err_sum - maj_twice) : err_sum;
                    if (x_major_reg || minor_step) begin
                        cur_x_next = x_stepped;
                    end
                    if (!x_major_reg || minor_step) begin
                        cur_y_next = y_stepped;
                    end
                end
                if ((cur_x_next == goal_x_reg) && (cur_y_next == goal_y_reg)) begin
                    active_next = 1'b0;
                end
            end
            lps_pkg::MODE_STOP: begin
                active_next = 1'b0;
            end
            default: begin
            end
        endcase

        result.pos_x   = lps_pkg::FIELD_BITS'(cur_x_next);
        result.pos_y   = lps_pkg::FIELD_BITS'(cur_y_next);
        result.moved   = moved;
        result.arrived = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
            delta_x_reg <= '0;
            delta_y_reg <= '0;
            x_down_reg  <= 1'b0;
            y_down_reg  <= 1'b0;
            x_major_reg <= 1'b1;
            err_reg     <= '0;
            active_reg  <= 1'b0;
        end else if (step_en) begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            goal_x_reg  <= goal_x_next;
            goal_y_reg  <= goal_y_next;
            delta_x_reg <= delta_x_next;
            delta_y_reg <= delta_y_next;
            x_down_reg  <= x_down_next;
            y_down_reg  <= y_down_next;
            x_major_reg <= x_major_next;
            err_reg     <= err_next;
            active_reg  <= active_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/line_path_stepper.sv
// Line path stepper: moves a point along a Bresenham line, one grid step per
// tick request.
// Input channel (s_): tuser carries the mode (start, tick, stop); tdata
// carries the start and target points, which only a start request uses.
// Result channel (m_): one result per request with the position after it,
// whether the request moved the point, and whether the point is on target.
// A request accepted into the input register is processed into the result
// register when that is free or emptying, and its result then shows on m_tvalid.
// Throughput: one request per cycle while m_tready stays high. Each request is
// one add, compare and subtract on the walker state, done combinationally
// between the input register and the result register.
// Reset (aresetn low, synchronous) puts the point at the origin, idle, and
// empties both registers.
// When the receiver holds m_tready low, the result register keeps its value
// and s_tready drops once the input register holds a request.
`default_nettype none

module line_path_stepper #(
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // start_x, start_y, target_x, target_y
    input  wire logic [1:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // pos_x, pos_y, moved, arrived, zero pad
);

    lps_pkg::item_t   in_item;
    lps_pkg::item_t   item;
    lps_pkg::result_t result;
    lps_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             item_valid;
    logic             advance;

    assign in_item = {s_tdata, s_tuser};

    lps_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (advance),
        .item       (item)
    );

    // A request is processed when the result register is free or emptying.
    assign advance        = item_valid && (!out_valid_reg || m_tready);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    lps_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

endmodule

`default_nettype wire

// File: tb/line_path_stepper_test.sv
`timescale 1ns / 100ps

module line_path_stepper_test;

    // Mode code 3 has no meaning; the block must ignore it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 60;

    // Predicts the walker and holds the results that are still due.
    class path_scoreboard;
        logic [15:0] cur_x, cur_y, goal_x, goal_y, span_x, span_y;
        bit x_down, y_down, x_major, walking;
        logic [17:0] err_acc;
        lps_pkg::result_t due_results[$];
        int errors;

        function new();
            cur_x = '0; cur_y = '0; goal_x = '0; goal_y = '0;
            span_x = '0; span_y = '0;
            x_down = 1'b0; y_down = 1'b0; x_major = 1'b1; walking = 1'b0;
            err_acc = '0;
            errors = 0;
        endfunction

        function bit on_goal();
            return cur_x == goal_x && cur_y == goal_y;
        endfunction

        function void note_request(logic [1:0] mode, logic [63:0] data);
            lps_pkg::result_t res;
            bit moved;
            moved = 0;
            case (mode)
                lps_pkg::MODE_START: begin
                    cur_x  = data[15:0];
                    cur_y  = data[31:16];
                    goal_x = data[47:32];
                    goal_y = data[63:48];
                    span_x = (cur_x >= goal_x) ? cur_x - goal_x : goal_x - cur_x;
                    span_y = (cur_y >= goal_y) ? cur_y - goal_y : goal_y - cur_y;
                    x_down = !(cur_x < goal_x);
                    y_down = !(cur_y < goal_y);
                    x_major = span_x >= span_y;
                    err_acc = x_major ? {2'b00, span_x} : {2'b00, span_y};
                    walking = !on_goal();
                end
                lps_pkg::MODE_TICK: begin
                    if (walking && !on_goal()) begin
                        if (x_major) begin
                            cur_x = x_down ? cur_x - 16'd1 : cur_x + 16'd1;
                            err_acc = err_acc + {1'b0, span_y, 1'b0};
                            if (err_acc > {1'b0, span_x, 1'b0}) begin
                                cur_y = y_down ? cur_y - 16'd1 : cur_y + 16'd1;
                                err_acc = err_acc - {1'b0, span_x, 1'b0};
                            end
                        end else begin
                            cur_y = y_down ? cur_y - 16'd1 : cur_y + 16'd1;
                            err_acc = err_acc + {1'b0, span_x, 1'b0};
                            if (err_acc > {1'b0, span_y, 1'b0}) begin
                                cur_x = x_down ? cur_x - 16'd1 : cur_x + 16'd1;
                                err_acc = err_acc - {1'b0, span_y, 1'b0};
                            end
                        end
                        moved = 1;
                    end
                    if (on_goal())
                        walking = 0;
                end
                lps_pkg::MODE_STOP: begin
                    walking = 0;
                end
                default: ;
            endcase
            res.pos_x   = cur_x;
            res.pos_y   = cur_y;
            res.moved   = moved;
            res.arrived = on_goal();
            due_results.push_back(res);
        endfunction

        function void check_result(logic [39:0] data);
            lps_pkg::result_t got, want;
            got = data[33:0];
            if (due_results.size() == 0) begin
                $error("result with no request pending: %h", data);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.pos_x !== want.pos_x) begin
                $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== want.pos_y) begin
                $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
                errors++;
            end
            if (got.moved !== want.moved) begin
                $error("moved: expected %0b, got %0b", want.moved, got.moved);
                errors++;
            end
            if (got.arrived !== want.arrived) begin
                $error("arrived: expected %0b, got %0b", want.arrived, got.arrived);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = lps_pkg::MODE_TICK;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;

    path_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent_count = 0;

    line_path_stepper dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off when the main flow asks for one.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            board.check_result(m_tdata);
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [63:0] points(logic [15:0] sx, logic [15:0] sy,
                                           logic [15:0] tx, logic [15:0] ty);
        return {ty, tx, sy, sx};
    endfunction

    function automatic logic [15:0] nearby(logic [15:0] c);
        int v;
        v = int'(c);
        v = v + int'($urandom_range(40)) - 20;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic logic [63:0] noise();
        return {$urandom, $urandom};
    endfunction

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(input logic [1:0] mode, input logic [63:0] data);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        board.note_request(mode, data);
        sent_count++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    // One path: a start, then ticks until it should arrive (a long line gets only
    // a short run), with the odd stop or unused mode mixed in.
    task automatic walk_path();
        logic [15:0] sx, sy, tx, ty;
        int dxi, dyi, steps, n, stop_at, pick;
        sx = 16'($urandom);
        sy = 16'($urandom);
        pick = $urandom_range(15);
        if (pick == 0) begin
            tx = sx; ty = sy;
        end else if (pick == 1) begin
            tx = 16'($urandom); ty = 16'($urandom);
        end else begin
            tx = nearby(sx); ty = nearby(sy);
        end
        send_request(lps_pkg::MODE_START, points(sx, sy, tx, ty));
        dxi = (sx >= tx) ? int'(sx - tx) : int'(tx - sx);
        dyi = (sy >= ty) ? int'(sy - ty) : int'(ty - sy);
        steps = (dxi > dyi) ? dxi : dyi;
        // Long lines only get a few steps to keep the run short.
        if (steps > 40) steps = $urandom_range(4);
        n = steps + $urandom_range(3);
        stop_at = ($urandom_range(9) == 0) ? $urandom_range(n) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == stop_at)
                send_request(lps_pkg::MODE_STOP, noise());
            else if ($urandom_range(19) == 0)
                send_request(MODE_UNUSED, noise());
            else
                send_request(lps_pkg::MODE_TICK, noise());
        end
    endtask

    initial begin
        int phase_goal;
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        send_request(lps_pkg::MODE_TICK, '0);
        send_request(MODE_UNUSED, '1);
        send_request(lps_pkg::MODE_START, points(16'd0, 16'd0, 16'd0, 16'd0));
        send_request(lps_pkg::MODE_TICK, '0);
        send_request(lps_pkg::MODE_START, points(16'd0, 16'd0, 16'd5, 16'd2));
        repeat (6) send_request(lps_pkg::MODE_TICK, '0);
        send_request(lps_pkg::MODE_START,
                     points(16'hFFFF, 16'hFFFF, 16'hFFFC, 16'hFFF8));
        repeat (3) send_request(lps_pkg::MODE_TICK, '1);
        send_request(lps_pkg::MODE_STOP, '0);
        send_request(lps_pkg::MODE_TICK, '0);
        send_request(lps_pkg::MODE_START,
                     points(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
        repeat (2) send_request(lps_pkg::MODE_TICK, '0);
        send_request(lps_pkg::MODE_START, points(16'd100, 16'd100, 16'd100, 16'd103));
        repeat (4) send_request(lps_pkg::MODE_TICK, '0);
        drain_results();

        // Random part in four idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            phase_goal = sent_count + 130;
            if (phase == 0) begin
                // Back up the block while the receiver holds off.
                hold_asks <= hold_asks + 1;
                send_request(lps_pkg::MODE_START, points(16'd10, 16'd20, 16'd40, 16'd5));
                repeat (20) send_request(lps_pkg::MODE_TICK, noise());
            end
            while (sent_count < phase_goal)
                walk_path();
            drain_results();
        end

        repeat (10) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
